/* rtl/tlvcl_pkg.sv */
// ----------------------------------------------------------------------------
// tlvcl_pkg
// Types and constants shared by the chunk locator modules.
// ----------------------------------------------------------------------------
package tlvcl_pkg;

  localparam int MEM_BYTES  = 4096;
  localparam int ADDR_W     = $clog2(MEM_BYTES);
  localparam int HDR_BYTES  = 4;
  localparam int WALK_START = 2;
  localparam int SIZE_W     = 16;
  // Positions never wrap: a sub region can end a full body size past memory,
  // and one more advance can go a full header plus body size beyond that.
  localparam int POS_W      = $clog2(MEM_BYTES + 2 * (HDR_BYTES + (1 << SIZE_W)));

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_FIND     = 2'd1,
    OP_FIND_SUB = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [11:0]       address;
    logic [7:0]        data_byte;
    logic [15:0]       chunk_sig;
    logic [15:0]       sub_sig;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [11:0]       body_address;
    logic [15:0]       body_size;
  } res_t;

  // Storage port controls from the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

/* rtl/tlv_chunk_locator_unit.sv */
// ----------------------------------------------------------------------------
// tlv_chunk_locator_unit
// Byte storage with a chunk header walker for signature lookups.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a request on req_i; the transfer happens on a clock edge
//   where start is high and busy is low. A write-byte request stores one byte
//   and busy stays low. A find request walks chunk headers
//   from address 2; a find-sub request walks the parent chain and then the
//   parent's body. Unused operation codes are dropped.
//   Each find or find-sub gives one result on res_o, marked by done_o for one
//   cycle. The receiver cannot stall; the result must be taken that cycle.
//   Each chunk header visited goes through a range check, four byte reads
//   through the single registered read port (address, then data), a compare,
//   then the advance or, on the last header, the result. A walk ends on a
//   match, on a zero size, or when it runs past the region end. Find-sub
//   visits the headers of both walks; the matching parent's advance slot
//   sets up the body range. busy drops in the result cycle, and the next
//   transfer can be taken there.
//   Reset: after rst_ni rises, a clearing pass zeroes all 4096 bytes, one per
//   cycle; busy is high throughout and no request is taken.
// ----------------------------------------------------------------------------
module tlv_chunk_locator_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  tlvcl_pkg::req_t req_i,
  output tlvcl_pkg::res_t res_o,
  output logic            done_o
);
  import tlvcl_pkg::*;

  mem_req_t   mem_req;
  logic [7:0] rdata;

  tlvcl_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .req_i     (req_i),
    .mem_req_o (mem_req),
    .rdata_i   (rdata),
    .res_o     (res_o),
    .done_o    (done_o)
  );

  tlvcl_mem u_mem (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (rdata)
  );

endmodule

/* rtl/tlvcl_mem.sv */
// ----------------------------------------------------------------------------
// tlvcl_mem
// Byte storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tlvcl_mem (
  input  logic              clk_i,
  input  tlvcl_pkg::mem_req_t mem_req_i,
  output logic [7:0]        rdata_o
);
  import tlvcl_pkg::*;

  logic [7:0] mem_q [MEM_BYTES];

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    rdata_o <= mem_q[mem_req_i.raddr];
  end

endmodule

/* rtl/tlvcl_seq.sv */
// ----------------------------------------------------------------------------
// tlvcl_seq
// Sequencer: clearing sweep, byte writes and the chunk header walk, built
// around one shared position adder.
// ----------------------------------------------------------------------------
module tlvcl_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  tlvcl_pkg::req_t     req_i,
  output tlvcl_pkg::mem_req_t mem_req_o,
  input  logic [7:0]          rdata_i,
  output tlvcl_pkg::res_t     res_o,
  output logic                done_o
);
  import tlvcl_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_CHECK  = 8'b0000_0100,
    S_ADDR   = 8'b0000_1000,
    S_DATA   = 8'b0001_0000,
    S_EVAL   = 8'b0010_0000,
    S_ADV    = 8'b0100_0000,
    S_SUBEND = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [1:0]        byte_q, byte_d;
  logic              sub_q, sub_d;
  logic              oor_q, oor_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  end_q, end_d;
  logic [15:0]       sig_q, sig_d;
  logic [15:0]       ssig_q, ssig_d;
  logic [31:0]       hdr_q, hdr_d;
  res_t              res_q, res_d;
  logic              done_q, done_d;

  logic [POS_W-1:0]  add_b;
  logic [POS_W-1:0]  sum;
  logic [7:0]        rd_byte;
  logic [15:0]       hdr_sig;
  logic [15:0]       hdr_size;

  assign hdr_sig  = hdr_q[15:0];
  assign hdr_size = hdr_q[31:16];

  // Shared adder: byte offsets, header skip and body size all go through it
  always_comb begin
    unique case (state_q)
      S_ADDR:          add_b = POS_W'(byte_q);
      S_EVAL:          add_b = POS_W'(HDR_BYTES);
      S_ADV, S_SUBEND: add_b = POS_W'(hdr_size);
      default:         add_b = '0;
    endcase
  end

  assign sum     = pos_q + add_b;
  assign rd_byte = oor_q ? 8'd0 : rdata_i;
  assign busy    = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    byte_d  = byte_q;
    sub_d   = sub_q;
    oor_d   = oor_q;
    pos_d   = pos_q;
    end_d   = end_q;
    sig_d   = sig_q;
    ssig_d  = ssig_q;
    hdr_d   = hdr_q;
    res_d   = res_q;
    done_d  = 1'b0;

    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = req_i.address[ADDR_W-1:0];
    mem_req_o.wdata = req_i.data_byte;
    mem_req_o.raddr = sum[ADDR_W-1:0];

    unique case (state_q)
      S_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = clr_q;
        mem_req_o.wdata = 8'd0;
        clr_d           = clr_q + 1'b1;
        if (clr_q == ADDR_W'(MEM_BYTES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          pos_d  = POS_W'(WALK_START);
          end_d  = POS_W'(MEM_BYTES);
          sig_d  = req_i.chunk_sig;
          ssig_d = req_i.sub_sig;
          case (op_e'(req_i.operation))
            OP_WRITE: mem_req_o.we = 1'b1;
            OP_FIND: begin
              sub_d   = 1'b0;
              state_d = S_CHECK;
            end
            OP_FIND_SUB: begin
              sub_d   = 1'b1;
              state_d = S_CHECK;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        byte_d = 2'd0;
        if (pos_q < end_q) begin
          state_d = S_ADDR;
        end else begin
          res_d   = '0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_ADDR: begin
        oor_d   = (sum >= POS_W'(MEM_BYTES));
        state_d = S_DATA;
      end
      S_DATA: begin
        hdr_d  = {rd_byte, hdr_q[31:8]};
        byte_d = byte_q + 1'b1;
        state_d = (byte_q == 2'd3) ? S_EVAL : S_ADDR;
      end
      S_EVAL: begin
        pos_d = sum;
        if (hdr_sig == sig_q) begin
          if (sub_q) begin
            // parent found: walk its body for the sub signature
            sig_d   = ssig_q;
            sub_d   = 1'b0;
            state_d = S_SUBEND;
          end else begin
            res_d.found        = 1'b1;
            res_d.body_address = sum[11:0];
            res_d.body_size    = hdr_size;
            done_d             = 1'b1;
            state_d            = S_IDLE;
          end
        end else if (hdr_size == 16'd0) begin
          res_d   = '0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_ADV;
        end
      end
      S_ADV: begin
        pos_d   = sum;
        state_d = S_CHECK;
      end
      S_SUBEND: begin
        end_d   = sum;
        state_d = S_CHECK;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      byte_q  <= '0;
      sub_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      byte_q  <= byte_d;
      sub_q   <= sub_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oor_q  <= oor_d;
    pos_q  <= pos_d;
    end_q  <= end_d;
    sig_q  <= sig_d;
    ssig_q <= ssig_d;
    hdr_q  <= hdr_d;
    res_q  <= res_d;
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

/* rtl/tlvcl_checker.sv */
// ----------------------------------------------------------------------------
// tlvcl_checker
// Port-level checks on the chunk locator, bound to the top level.
// ----------------------------------------------------------------------------
module tlvcl_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input tlvcl_pkg::req_t req_i,
  input tlvcl_pkg::res_t res_o,
  input logic            done_o
);
  import tlvcl_pkg::*;

  // a result only follows a cycle of work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy) && !busy)
    else $error("result without preceding work");

  // not found reports zero address and size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.found) |-> (res_o.body_address == 12'd0 && res_o.body_size == 16'd0))
    else $error("not-found result with nonzero fields");

  // a find transfer starts a walk; no result right away
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.operation == OP_FIND || req_i.operation == OP_FIND_SUB))
      |=> (busy && !done_o))
    else $error("find did not start a walk");

  // a byte write completes in the cycle it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.operation == OP_WRITE) |=> (!busy && !done_o))
    else $error("byte write stalled or produced a result");

endmodule

bind tlv_chunk_locator_unit tlvcl_checker u_tlvcl_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .res_o  (res_o),
  .done_o (done_o)
);
